### rtl/clb_config_bit_locator_core_macros.svh
// Assertion macros for the CLB configuration bit locator.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef CLB_CONFIG_BIT_LOCATOR_CORE_MACROS_SVH
`define CLB_CONFIG_BIT_LOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("clb locator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("clb locator: next-cycle check failed");

`endif

### rtl/clb_pkg.sv
// Shared types and constants for the CLB configuration bit locator.
// No dependencies; imported by every module of the block.
`default_nettype none

package clb_pkg;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_CLOCK_REGIONS    = 3'd0;
    localparam logic [2:0] REG_CLB_ROW_COUNT    = 3'd1;
    localparam logic [2:0] REG_CLB_COLUMN_COUNT = 3'd2;
    localparam logic [2:0] REG_FRAME_WORDS      = 3'd3;
    localparam logic [2:0] REG_FAMILY_SELECT    = 3'd4;
    localparam logic [2:0] REG_SKIP_TABLE       = 3'd5;

    localparam logic [3:0]  RST_CLOCK_REGIONS    = 4'd2;
    localparam logic [7:0]  RST_CLB_ROW_COUNT    = 8'd100;
    localparam logic [7:0]  RST_CLB_COLUMN_COUNT = 8'd100;
    localparam logic [6:0]  RST_FRAME_WORDS      = 7'd101;
    localparam logic        RST_FAMILY_SELECT    = 1'b0;
    localparam logic [63:0] RST_SKIP_TABLE       = '1;

    localparam int DEF_SKIP_ENTRIES      = 8;
    localparam int DEF_FRAMES_PER_ACCESS = 4;

    localparam logic [5:0] MINOR_LOW  = 6'd26;
    localparam logic [5:0] MINOR_HIGH = 6'd32;

    // The divider works on 8-bit operands, one quotient bit per step.
    localparam int DIV_BITS  = 8;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    typedef struct packed {
        logic [3:0]  clock_regions;
        logic [7:0]  clb_row_count;
        logic [7:0]  clb_column_count;
        logic [6:0]  frame_words;
        logic        family_select;
        logic [63:0] skip_table;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic start2;
        logic finish;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_SETUP2,
        ST_DIV2,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/clb_regs.sv
// Configuration register file with its APB-style access port.
// Depends on clb_pkg for the register map and reset values.
`default_nettype none

module clb_regs import clb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CLOCK_REGIONS:    cfg_next.clock_regions    = pwdata[3:0];
                REG_CLB_ROW_COUNT:    cfg_next.clb_row_count    = pwdata[7:0];
                REG_CLB_COLUMN_COUNT: cfg_next.clb_column_count = pwdata[7:0];
                REG_FRAME_WORDS:      cfg_next.frame_words      = pwdata[6:0];
                REG_FAMILY_SELECT:    cfg_next.family_select    = pwdata[0];
                REG_SKIP_TABLE:       cfg_next.skip_table       = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clock_regions    <= RST_CLOCK_REGIONS;
            cfg_reg.clb_row_count    <= RST_CLB_ROW_COUNT;
            cfg_reg.clb_column_count <= RST_CLB_COLUMN_COUNT;
            cfg_reg.frame_words      <= RST_FRAME_WORDS;
            cfg_reg.family_select    <= RST_FAMILY_SELECT;
            cfg_reg.skip_table       <= RST_SKIP_TABLE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLOCK_REGIONS:    prdata = CFG_DATA_W'(cfg_reg.clock_regions);
            REG_CLB_ROW_COUNT:    prdata = CFG_DATA_W'(cfg_reg.clb_row_count);
            REG_CLB_COLUMN_COUNT: prdata = CFG_DATA_W'(cfg_reg.clb_column_count);
            REG_FRAME_WORDS:      prdata = CFG_DATA_W'(cfg_reg.frame_words);
            REG_FAMILY_SELECT:    prdata = CFG_DATA_W'(cfg_reg.family_select);
            REG_SKIP_TABLE:       prdata = cfg_reg.skip_table;
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/clb_ctrl.sv
// Sequencing state machine: request handshake, divider step count, result valid.
// Depends on clb_pkg for the state and command types.
`default_nettype none

module clb_ctrl import clb_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 cnt_last;
    logic                 out_free;

    assign cnt_last = (cnt_reg == DIV_CNT_W'(DIV_BITS - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DIV1;
            ST_DIV1:   if (cnt_last) state_next = ST_SETUP2;
            ST_SETUP2: state_next = ST_DIV2;
            ST_DIV2:   if (cnt_last) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands, step counter and result valid.
    always_comb begin
        cmd      = '0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                cnt_next = '0;
            end
            ST_DIV1, ST_DIV2: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SETUP2: begin
                cmd.start2 = 1'b1;
                cnt_next   = '0;
            end
            ST_DONE: begin
                cmd.finish = out_free;
            end
            default: ;
        endcase
        m_valid_next = cmd.finish || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/clb_dpath.sv
// Datapath: request registers, shared restoring divider, address arithmetic, result register.
// Depends on clb_pkg for the configuration and command types and constants.
`default_nettype none

module clb_dpath import clb_pkg::*; #(
    parameter int SKIP_ENTRIES      = DEF_SKIP_ENTRIES,
    parameter int FRAMES_PER_ACCESS = DEF_FRAMES_PER_ACCESS
) (
    input  wire logic       aclk,
    input  wire cfg_t       cfg,
    input  wire cmd_t       cmd,
    input  wire logic [7:0] s_slice_y,
    input  wire logic [8:0] s_slice_column,
    input  wire logic [5:0] s_bit_select,
    input  wire logic [5:0] s_minor_frame,
    output logic            m_bottom_half,
    output logic [3:0]      m_region_row,
    output logic [9:0]      m_major_address,
    output logic [5:0]      m_minor_base,
    output logic [9:0]      m_word_index,
    output logic [4:0]      m_bit_index,
    output logic            m_range_error
);

    localparam int SKIP_W = $clog2(SKIP_ENTRIES + 1);
    localparam int REL_W  = (FRAMES_PER_ACCESS > 1) ? $clog2(FRAMES_PER_ACCESS) : 1;

    logic [7:0] row_reg;
    logic [8:0] col_reg;
    logic [5:0] bsel_reg;
    logic [5:0] minor_reg;
    logic [7:0] divisor_reg;
    logic [7:0] quo_reg;
    logic [7:0] rem_reg;
    logic       zero_err_reg;

    logic [8:0] trial;
    logic       fits;
    logic [8:0] diff;
    logic       per_bad;
    logic [7:0] per_calc;

    logic [7:0]        clb;
    logic [SKIP_W-1:0] skips;
    logic [3:0]        mid;
    logic [8:0]        grp;
    logic [8:0]        mid9;
    logic              bottom;
    logic [8:0]        crow_full;
    logic [8:0]        woff;
    logic [5:0]        base;
    logic [5:0]        rel_full;
    logic              in_win;
    logic [REL_W-1:0]  rel;
    logic [9:0]        word;
    logic              coord_err;

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg, quo_reg[7]};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign diff     = trial - {1'b0, divisor_reg};
    assign per_bad  = (cfg.clock_regions == 4'd0) || (quo_reg == 8'd0);
    assign per_calc = per_bad ? 8'd1 : quo_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            row_reg     <= s_slice_y;
            col_reg     <= s_slice_column;
            bsel_reg    <= s_bit_select;
            minor_reg   <= s_minor_frame;
            quo_reg     <= cfg.clb_row_count;
            rem_reg     <= '0;
            divisor_reg <= {4'd0, cfg.clock_regions};
        end else if (cmd.step) begin
            quo_reg <= {quo_reg[6:0], fits};
            rem_reg <= fits ? diff[7:0] : trial[7:0];
        end else if (cmd.start2) begin
            // Rows per region is known; now divide the slice row by it.
            zero_err_reg <= per_bad;
            divisor_reg  <= per_calc;
            quo_reg      <= row_reg;
            rem_reg      <= '0;
        end
    end

    assign clb = col_reg[8:1];

    always_comb begin
        skips = SKIP_W'(SKIP_ENTRIES);
        for (int k = SKIP_ENTRIES - 1; k >= 0; k--) begin
            if (cfg.skip_table[8*k +: 8] > clb) skips = SKIP_W'(k);
        end
    end

    always_comb begin
        if (!cfg.clock_regions[0]) begin
            mid = (cfg.clock_regions >> 1) + {3'd0, cfg.family_select};
        end else begin
            mid = (cfg.clock_regions >> 1) + {3'd0, !cfg.family_select};
        end
    end

    assign grp       = {1'b0, quo_reg} + 9'd1;
    assign mid9      = {5'd0, mid};
    assign bottom    = (grp <= mid9);
    assign crow_full = bottom ? (mid9 - grp) : (grp - mid9 - 9'd1);

    assign woff = {rem_reg, (rem_reg >= (divisor_reg >> 1))};

    assign base     = minor_reg[5] ? MINOR_HIGH : MINOR_LOW;
    assign rel_full = minor_reg - base;
    assign in_win   = (minor_reg >= base) && (rel_full < 6'(FRAMES_PER_ACCESS));
    assign rel      = in_win ? rel_full[REL_W-1:0] : '0;
    assign word     = 10'(rel) * 10'(cfg.frame_words) + 10'(woff) + 10'(!bsel_reg[5]);

    assign coord_err = (row_reg >= cfg.clb_row_count) ||
                       (col_reg >= {cfg.clb_column_count, 1'b0});

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_bottom_half   <= bottom;
            m_region_row    <= crow_full[3:0];
            m_major_address <= 10'(clb) + 10'(skips);
            m_minor_base    <= base;
            m_word_index    <= word;
            m_bit_index     <= bsel_reg[4:0];
            m_range_error   <= zero_err_reg || coord_err || !in_win;
        end
    end

endmodule

`default_nettype wire

### rtl/clb_config_bit_locator_core.sv
// Top level of the CLB configuration bit locator: register file, controller, datapath.
// Depends on clb_pkg, clb_regs, clb_ctrl, clb_dpath and the assertion macro header.
`default_nettype none
`include "clb_config_bit_locator_core_macros.svh"

// For each request (a slice coordinate plus one LUT resource bit) this block returns where the
// bit lives in configuration memory: top or bottom half, clock row inside that half, the major
// column address after counting the skip-table thresholds the CLB column has reached, the first
// minor frame of the four-frame read window (26 or 32), the word index inside the window's data,
// the bit index inside that word, and a range error flag. One request is processed at a time and
// its result is loaded into the output register in the ST_DONE state, after both divider passes
// and once any earlier result has been taken; the next request can be accepted in the cycle
// after that load. The work is done by a single 8-bit restoring divider that produces one
// quotient bit per cycle and is used twice (with a setup state between the two passes and a
// final state to load the result): first to find the rows per clock region, then to split the
// slice row into region and offset. The result sits in an output register, so a new request can
// be taken while the previous result still waits for m_ready; the load of the next result then
// waits until that one is taken. Configuration registers sit on an APB-style port, 64-bit data,
// each register at byte address 8 times its index; pready is always high. Registers should only
// be written while no request is outstanding.
module clb_config_bit_locator_core import clb_pkg::*; #(
    parameter int SKIP_ENTRIES      = DEF_SKIP_ENTRIES,
    parameter int FRAMES_PER_ACCESS = DEF_FRAMES_PER_ACCESS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // Request channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_slice_y,
    input  wire logic [8:0]            s_slice_column,
    input  wire logic [5:0]            s_bit_select,
    input  wire logic [5:0]            s_minor_frame,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_bottom_half,
    output logic [3:0]                 m_region_row,
    output logic [9:0]                 m_major_address,
    output logic [5:0]                 m_minor_base,
    output logic [9:0]                 m_word_index,
    output logic [4:0]                 m_bit_index,
    output logic                       m_range_error
);

    cfg_t cfg;
    cmd_t cmd;

    // The register file holds the device geometry and the skip table.
    clb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns both handshakes and steps the divider.
    clb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath does the arithmetic and holds the result register.
    clb_dpath #(
        .SKIP_ENTRIES      (SKIP_ENTRIES),
        .FRAMES_PER_ACCESS (FRAMES_PER_ACCESS)
    ) u_dpath (
        .aclk            (aclk),
        .cfg             (cfg),
        .cmd             (cmd),
        .s_slice_y       (s_slice_y),
        .s_slice_column  (s_slice_column),
        .s_bit_select    (s_bit_select),
        .s_minor_frame   (s_minor_frame),
        .m_bottom_half   (m_bottom_half),
        .m_region_row    (m_region_row),
        .m_major_address (m_major_address),
        .m_minor_base    (m_minor_base),
        .m_word_index    (m_word_index),
        .m_bit_index     (m_bit_index),
        .m_range_error   (m_range_error)
    );

    // Only one request is in flight: after an acceptance the input side closes.
    `CLB_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    // A result is never loaded over one that has not been taken.
    `CLB_ASSERT_SAME(a_no_overwrite, cmd.finish, !m_valid || m_ready)
    // The datapath captures request fields only on an actual acceptance.
    `CLB_ASSERT_SAME(a_load_on_accept, cmd.load, s_valid && s_ready)

endmodule

`default_nettype wire
